// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check of a property on the rising edge of clk, idle while in reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent check that a condition implies another one on the next edge.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/mdr_pkg.sv =====
`timescale 1ns / 1ps

package mdr_pkg;

    // Pose word, Q15.16.
    typedef logic signed [31:0] pose_t;

    // CORDIC rotation count and arctangent table depth.
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;

    // Bit-serial units.
    localparam int MOD_BITS = 33;
    localparam int MUL_BITS = 16;
    localparam int CNT_W    = 6;

    // Angle reduction. The offset is a multiple of two pi that makes any heading positive.
    localparam logic [32:0]        THETA_OFFSET = 33'd2147818400;
    localparam logic [19:0]        Q_TWO_PI     = 20'd411775;
    localparam logic signed [20:0] Q_TWO_PI_S   = 21'sd411775;
    localparam logic signed [20:0] Q_PI_S       = 21'sd205887;
    localparam logic signed [20:0] Q_HALF_PI_S  = 21'sd102944;

    // CORDIC start vector length in Q30.
    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

    // Count scaling: counts * 65536 / 376 and heading step counts * 81920 / 3243, both
    // rounded half away from zero. The divisions work on the magnitude through a
    // reciprocal multiplication that is exact over the whole 8-bit count range. For the
    // position the divisor 376 is split into a shift by three and a division by 47.
    localparam logic [20:0] COUNT_BIAS  = 21'd23;
    localparam logic [20:0] COUNT_RECIP = 21'd1427849;
    localparam int          COUNT_SHIFT = 26;
    localparam logic [23:0] HEAD_BIAS   = 24'd1621;
    localparam logic [23:0] HEAD_RECIP  = 24'd10595048;
    localparam int          HEAD_SHIFT  = 35;

    // Wheel trim codes.
    localparam logic [1:0] TRIM_NONE = 2'd0;
    localparam logic [1:0] TRIM_DEC  = 2'd1;
    localparam logic [1:0] TRIM_INC  = 2'd2;

    // Scaled mouse count in Q16, rounded with ties away from zero.
    function automatic logic signed [15:0] count_to_q16(input logic signed [7:0] c);
        logic [7:0]  mag;
        logic [20:0] m;
        logic [41:0] p;
        logic [15:0] q;
        mag = c[7] ? 8'd0 - unsigned'(c) : unsigned'(c);
        // The multiple of 65536 keeps the shift by three exact.
        m = {mag, 13'd0} + COUNT_BIAS;
        p = 42'(m) * 42'(COUNT_RECIP);
        q = p[COUNT_SHIFT+15:COUNT_SHIFT];
        if (c[7])
            return 16'sd0 - signed'(q);
        return signed'(q);
    endfunction

    // Heading step in Q16 for a dy count, rounded with ties away from zero.
    function automatic logic signed [12:0] heading_step(input logic signed [7:0] c);
        logic [7:0]  mag;
        logic [23:0] n;
        logic [47:0] p;
        logic [12:0] q;
        mag = c[7] ? 8'd0 - unsigned'(c) : unsigned'(c);
        // The factor 81920 is 2^16 + 2^14.
        n = {mag, 16'd0} + {2'b00, mag, 14'd0} + HEAD_BIAS;
        p = 48'(n) * 48'(HEAD_RECIP);
        q = p[HEAD_SHIFT+12:HEAD_SHIFT];
        if (c[7])
            return 13'sd0 - signed'(q);
        return signed'(q);
    endfunction

    // Arctangent of 2^-i in Q16.
    function automatic logic [15:0] atan_q16(input logic [4:0] i);
        logic [15:0] v;
        case (i)
            5'd0:    v = 16'd51472;
            5'd1:    v = 16'd30385;
            5'd2:    v = 16'd16055;
            5'd3:    v = 16'd8150;
            5'd4:    v = 16'd4091;
            5'd5:    v = 16'd2047;
            5'd6:    v = 16'd1024;
            5'd7:    v = 16'd512;
            5'd8:    v = 16'd256;
            5'd9:    v = 16'd128;
            5'd10:   v = 16'd64;
            5'd11:   v = 16'd32;
            5'd12:   v = 16'd16;
            5'd13:   v = 16'd8;
            5'd14:   v = 16'd4;
            5'd15:   v = 16'd2;
            5'd16:   v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/mouse_dead_reckoning_core.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Dead-reckoning odometry from optical-mouse motion reports. Each input transaction is
// either a motion report (dx, dy, driving) or a clear command (tuser high), and each
// produces exactly one output transaction carrying the updated pose x, y, heading
// (Q15.16, saturating) and a wheel trim code. A motion report passes in turn through the
// bit-serial reduction of the heading modulo two pi, a step that folds the angle, the
// CORDIC unit (one rotation per cycle), the bit-serial multipliers for x and y (run in
// parallel) and a commit step; a new transaction is taken only once the sequencer is back
// in idle after the commit. A clear command goes from acceptance straight to the commit.
// The commit waits while the output register still holds an untaken result, and the input
// stays closed meanwhile. A finished result waits in the output register while the next
// transaction is already being worked on.
module mouse_dead_reckoning_core
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // dx [7:0], dy [15:8], driving [16], zero [23:17]
    input  logic [0:0]   s_tuser,   // kind [0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata    // pos_x [31:0], pos_y [63:32], heading [95:64],
                                    // trim [97:96], zero [103:98]
);

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MOD    = 3'd1;
    localparam logic [2:0] S_FOLD   = 3'd2;
    localparam logic [2:0] S_CORDIC = 3'd3;
    localparam logic [2:0] S_MUL    = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    // Saturate a 33-bit sum to the pose range.
    function automatic mdr_pkg::pose_t sat33(input logic signed [32:0] v);
        mdr_pkg::pose_t r;
        if (v[32] != v[31])
            r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            r = v[31:0];
        return r;
    endfunction

    logic [2:0]                    state_reg, state_next;
    logic [mdr_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic                          kind_reg, kind_next;
    logic                          drv_reg, drv_next;
    logic signed [7:0]             dx_reg, dx_next;
    logic signed [7:0]             dy_reg, dy_next;
    mdr_pkg::pose_t                x_acc_reg, x_acc_next;
    mdr_pkg::pose_t                y_acc_reg, y_acc_next;
    mdr_pkg::pose_t                th_acc_reg, th_acc_next;
    logic [32:0]                   mod_sh_reg, mod_sh_next;
    logic [18:0]                   r_reg, r_next;
    logic                          neg_reg, neg_next;
    logic signed [19:0]            z_reg, z_next;
    logic signed [31:0]            cx_reg, cx_next;
    logic signed [31:0]            cy_reg, cy_next;
    logic signed [47:0]            mc_x_reg, mc_x_next;
    logic signed [47:0]            mc_y_reg, mc_y_next;
    logic signed [47:0]            acc_x_reg, acc_x_next;
    logic signed [47:0]            acc_y_reg, acc_y_next;
    logic [mdr_pkg::MUL_BITS-1:0]  mp_x_reg, mp_x_next;
    logic [mdr_pkg::MUL_BITS-1:0]  mp_y_reg, mp_y_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [103:0]                  m_tdata_reg, m_tdata_next;

    logic                          in_fire;
    logic                          out_free;
    logic [19:0]                   mod_trial;
    logic signed [20:0]            fold_r;
    logic                          fold_neg;
    logic signed [31:0]            x_sh;
    logic signed [31:0]            y_sh;
    logic signed [19:0]            atan_s;
    logic signed [47:0]            x_ext;
    logic signed [47:0]            y_ext;
    logic signed [15:0]            adj_x;
    logic signed [15:0]            adj_y;
    logic                          mul_last;
    logic signed [47:0]            rnd_x;
    logic signed [47:0]            rnd_y;
    logic signed [12:0]            dth;
    mdr_pkg::pose_t                new_x;
    mdr_pkg::pose_t                new_y;
    mdr_pkg::pose_t                new_th;
    logic [1:0]                    trim;

    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Datapath helpers shared by the sequencer below.
    always_comb
    begin
        // One restoring step of the modulo-two-pi reduction.
        mod_trial = {r_reg, mod_sh_reg[32]};

        // Fold the reduced angle into [-pi/2, pi/2].
        fold_r   = signed'({2'b00, r_reg});
        fold_neg = 1'b0;
        if (fold_r >= mdr_pkg::Q_PI_S)
            fold_r = fold_r - mdr_pkg::Q_TWO_PI_S;
        if (fold_r > mdr_pkg::Q_HALF_PI_S)
        begin
            fold_r   = fold_r - mdr_pkg::Q_PI_S;
            fold_neg = 1'b1;
        end
        else if (fold_r < -mdr_pkg::Q_HALF_PI_S)
        begin
            fold_r   = fold_r + mdr_pkg::Q_PI_S;
            fold_neg = 1'b1;
        end

        // CORDIC rotation operands.
        x_sh   = cx_reg >>> cnt_reg[4:0];
        y_sh   = cy_reg >>> cnt_reg[4:0];
        atan_s = signed'({4'b0000, mdr_pkg::atan_q16(cnt_reg[4:0])});

        // Sign-extended and optionally negated trig results.
        x_ext = signed'({{16{cx_reg[31]}}, cx_reg});
        y_ext = signed'({{16{cy_reg[31]}}, cy_reg});
        if (neg_reg)
        begin
            x_ext = -x_ext;
            y_ext = -y_ext;
        end
        adj_x    = mdr_pkg::count_to_q16(dx_reg);
        adj_y    = mdr_pkg::count_to_q16(dy_reg);
        mul_last = (cnt_reg == mdr_pkg::CNT_W'(mdr_pkg::MUL_BITS - 1));

        // Final rounding, pose update and trim.
        rnd_x  = acc_x_reg + 48'sd536870912;
        rnd_y  = acc_y_reg + 48'sd536870912;
        dth    = mdr_pkg::heading_step(dy_reg);
        new_x  = sat33(signed'({x_acc_reg[31], x_acc_reg})
                       + signed'({{15{rnd_x[47]}}, rnd_x[47:30]}));
        new_y  = sat33(signed'({y_acc_reg[31], y_acc_reg})
                       + signed'({{15{rnd_y[47]}}, rnd_y[47:30]}));
        new_th = sat33(signed'({th_acc_reg[31], th_acc_reg})
                       + signed'({{20{dth[12]}}, dth}));
        trim   = mdr_pkg::TRIM_NONE;
        if (drv_reg)
        begin
            if (new_th > th_acc_reg)
                trim = mdr_pkg::TRIM_DEC;
            else if (new_th < th_acc_reg)
                trim = mdr_pkg::TRIM_INC;
        end
    end

    // Sequencer and next-state logic.
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        kind_next     = kind_reg;
        drv_next      = drv_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        x_acc_next    = x_acc_reg;
        y_acc_next    = y_acc_reg;
        th_acc_next   = th_acc_reg;
        mod_sh_next   = mod_sh_reg;
        r_next        = r_reg;
        neg_next      = neg_reg;
        z_next        = z_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        mc_x_next     = mc_x_reg;
        mc_y_next     = mc_y_reg;
        acc_x_next    = acc_x_reg;
        acc_y_next    = acc_y_reg;
        mp_x_next     = mp_x_reg;
        mp_y_next     = mp_y_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        // The output transaction completes.
        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    kind_next   = s_tuser[0];
                    dx_next     = signed'(s_tdata[7:0]);
                    dy_next     = signed'(s_tdata[15:8]);
                    drv_next    = s_tdata[16];
                    mod_sh_next = {th_acc_reg[31], th_acc_reg} + mdr_pkg::THETA_OFFSET;
                    r_next      = '0;
                    cnt_next    = '0;
                    state_next  = s_tuser[0] ? S_DONE : S_MOD;
                end
            end

            // Bit-serial reduction of the offset heading modulo two pi.
            S_MOD:
            begin
                if (mod_trial >= mdr_pkg::Q_TWO_PI)
                    r_next = 19'(mod_trial - mdr_pkg::Q_TWO_PI);
                else
                    r_next = mod_trial[18:0];
                mod_sh_next = {mod_sh_reg[31:0], 1'b0};
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == mdr_pkg::CNT_W'(mdr_pkg::MOD_BITS - 1))
                    state_next = S_FOLD;
            end

            S_FOLD:
            begin
                z_next     = 20'(fold_r);
                neg_next   = fold_neg;
                cx_next    = mdr_pkg::CORDIC_GAIN;
                cy_next    = '0;
                cnt_next   = '0;
                state_next = S_CORDIC;
            end

            // One CORDIC rotation per cycle.
            S_CORDIC:
            begin
                if (!z_reg[19])
                begin
                    cx_next = cx_reg - y_sh;
                    cy_next = cy_reg + x_sh;
                    z_next  = z_reg - atan_s;
                end
                else
                begin
                    cx_next = cx_reg + y_sh;
                    cy_next = cy_reg - x_sh;
                    z_next  = z_reg + atan_s;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == mdr_pkg::CNT_W'(mdr_pkg::CORDIC_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_MUL;
                end
            end

            // Shift-add multipliers, one bit of the scaled count per cycle.
            S_MUL:
            begin
                if (cnt_reg == '0)
                begin
                    // First step loads the operands and consumes bit zero.
                    mc_x_next  = x_ext <<< 1;
                    mc_y_next  = y_ext <<< 1;
                    acc_x_next = adj_x[0] ? x_ext : '0;
                    acc_y_next = adj_y[0] ? y_ext : '0;
                    mp_x_next  = {1'b0, adj_x[15:1]};
                    mp_y_next  = {1'b0, adj_y[15:1]};
                end
                else
                begin
                    if (mp_x_reg[0])
                        acc_x_next = mul_last ? acc_x_reg - mc_x_reg : acc_x_reg + mc_x_reg;
                    if (mp_y_reg[0])
                        acc_y_next = mul_last ? acc_y_reg - mc_y_reg : acc_y_reg + mc_y_reg;
                    mc_x_next = mc_x_reg <<< 1;
                    mc_y_next = mc_y_reg <<< 1;
                    mp_x_next = {1'b0, mp_x_reg[mdr_pkg::MUL_BITS-1:1]};
                    mp_y_next = {1'b0, mp_y_reg[mdr_pkg::MUL_BITS-1:1]};
                end
                cnt_next = cnt_reg + 1'b1;
                if (mul_last)
                    state_next = S_DONE;
            end

            // Commit the pose and load the output register once it is free.
            S_DONE:
            begin
                if (out_free)
                begin
                    if (kind_reg)
                    begin
                        x_acc_next  = '0;
                        y_acc_next  = '0;
                        th_acc_next = '0;
                        m_tdata_next = '0;
                    end
                    else
                    begin
                        x_acc_next   = new_x;
                        y_acc_next   = new_y;
                        th_acc_next  = new_th;
                        m_tdata_next = {6'b0, trim, new_th, new_y, new_x};
                    end
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            kind_reg     <= 1'b0;
            drv_reg      <= 1'b0;
            dx_reg       <= '0;
            dy_reg       <= '0;
            x_acc_reg    <= '0;
            y_acc_reg    <= '0;
            th_acc_reg   <= '0;
            mod_sh_reg   <= '0;
            r_reg        <= '0;
            neg_reg      <= 1'b0;
            z_reg        <= '0;
            cx_reg       <= '0;
            cy_reg       <= '0;
            mc_x_reg     <= '0;
            mc_y_reg     <= '0;
            acc_x_reg    <= '0;
            acc_y_reg    <= '0;
            mp_x_reg     <= '0;
            mp_y_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            kind_reg     <= kind_next;
            drv_reg      <= drv_next;
            dx_reg       <= dx_next;
            dy_reg       <= dy_next;
            x_acc_reg    <= x_acc_next;
            y_acc_reg    <= y_acc_next;
            th_acc_reg   <= th_acc_next;
            mod_sh_reg   <= mod_sh_next;
            r_reg        <= r_next;
            neg_reg      <= neg_next;
            z_reg        <= z_next;
            cx_reg       <= cx_next;
            cy_reg       <= cy_next;
            mc_x_reg     <= mc_x_next;
            mc_y_reg     <= mc_y_next;
            acc_x_reg    <= acc_x_next;
            acc_y_reg    <= acc_y_next;
            mp_x_reg     <= mp_x_next;
            mp_y_reg     <= mp_y_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
        end
    end

    // Checks on the sequencer and the serial units.
    `ASSERT_NEXT(a_accept_leaves_idle, in_fire, state_reg != S_IDLE, "transaction not started")
    `ASSERT_CLK(a_result_from_done, $rose(m_tvalid_reg) |-> $past(state_reg) == S_DONE,
                "result loaded outside the commit state")
    `ASSERT_CLK(a_mod_below_two_pi, state_reg == S_MOD |-> {1'b0, r_reg} < mdr_pkg::Q_TWO_PI,
                "remainder left the modulo range")
    `ASSERT_CLK(a_cordic_count,
                state_reg == S_CORDIC |-> cnt_reg < mdr_pkg::CNT_W'(mdr_pkg::CORDIC_STEPS),
                "CORDIC step count overran")

endmodule
